/* design/dscsd_pkg.sv */
package dscsd_pkg;

  // Default sizes of the dictionary.
  localparam int NUM_WORDS_DEF  = 8192;
  localparam int WORD_SLOTS_DEF = 32;

  // Field widths.
  localparam int FUNC_W  = 2;
  localparam int SYM_W   = 16;
  localparam int POS_W   = 5;
  localparam int BYTE_W  = 8;
  localparam int LEN_W   = 6;
  localparam int COUNT_W = 14;

  // Function codes.
  localparam logic [FUNC_W-1:0] FN_LOAD    = 2'd0;
  localparam logic [FUNC_W-1:0] FN_DECODE  = 2'd1;
  localparam logic [FUNC_W-1:0] FN_RESTART = 2'd2;

  // Control bytes of the case/space scheme.
  localparam logic [BYTE_W-1:0] CTL_NOSPACE    = 8'd1;
  localparam logic [BYTE_W-1:0] CTL_CAPS_ALL   = 8'd2;
  localparam logic [BYTE_W-1:0] CTL_CAPS_FIRST = 8'd3;
  localparam logic [BYTE_W-1:0] CTL_LITERAL    = 8'd4;

  // Character codes.
  localparam logic [BYTE_W-1:0] CH_LOWER_A = 8'h61;
  localparam logic [BYTE_W-1:0] CH_LOWER_Z = 8'h7a;
  localparam logic [BYTE_W-1:0] CH_UPPER_A = 8'h41;
  localparam logic [BYTE_W-1:0] CH_SPACE   = 8'h20;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [SYM_W-1:0]  symbol;
    logic [POS_W-1:0]  position;
    logic [BYTE_W-1:0] load_byte;
    logic              load_last;
  } in_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              byte_valid;
    logic              bad_symbol;
    logic              last;
  } out_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;       // store the input byte (and length on the final byte)
    logic restart;    // clear the case/space state
    logic bad;        // emit the invalid-symbol result
    logic dec;        // capture the word base address
    logic len_latch;  // capture the word length read from memory
    logic issue;      // read the next word byte
    logic finish;     // emit the final result of the decode
  } dp_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic bad;   // the input symbol is not a valid entry
    logic more;  // word bytes remain to be read
    logic rv;    // a read byte is in flight to the case/space machine
  } dp_sts_t;

endpackage

/* design/dscsd_ram.sv */
module dscsd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* design/dscsd_ctrl.sv */
module dscsd_ctrl (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [dscsd_pkg::FUNC_W-1:0] func,
  input  dscsd_pkg::dp_sts_t           sts,
  output dscsd_pkg::dp_cmd_t           cmd,
  output logic                         busy
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_LEN  = 2'd1;
  localparam logic [1:0] S_WALK = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          case (func)
            dscsd_pkg::FN_LOAD: begin
              cmd.load = 1'b1;
            end
            dscsd_pkg::FN_DECODE: begin
              if (sts.bad) begin
                cmd.bad = 1'b1;
              end else begin
                cmd.dec   = 1'b1;
                state_nxt = S_LEN;
              end
            end
            dscsd_pkg::FN_RESTART: begin
              cmd.restart = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      S_LEN: begin
        cmd.len_latch = 1'b1;
        state_nxt     = S_WALK;
      end
      S_WALK: begin
        if (sts.more) begin
          cmd.issue = 1'b1;
        end else if (!sts.rv) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

/* design/dscsd_dp.sv */
module dscsd_dp #(
  parameter int NUM_WORDS  = dscsd_pkg::NUM_WORDS_DEF,
  parameter int WORD_SLOTS = dscsd_pkg::WORD_SLOTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  dscsd_pkg::in_t                in_data,
  input  logic                          cfg_we,
  input  logic [dscsd_pkg::COUNT_W-1:0] cfg_wdata,
  input  dscsd_pkg::dp_cmd_t            cmd,
  output dscsd_pkg::dp_sts_t            sts,
  output logic                          out_valid,
  output dscsd_pkg::out_t               out_data
);

  localparam int BYTE_DEPTH = NUM_WORDS * WORD_SLOTS;
  localparam int ABW        = (BYTE_DEPTH > 1) ? $clog2(BYTE_DEPTH) : 1;
  localparam int WIW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int BW         = dscsd_pkg::BYTE_W;
  localparam int LW         = dscsd_pkg::LEN_W;

  // Configuration.
  logic [dscsd_pkg::COUNT_W-1:0] word_count_r;

  // Decode sequencing.
  logic [ABW-1:0] base_r, base_nxt;
  logic [LW-1:0]  len_r, len_nxt;
  logic [LW-1:0]  idx_r, idx_nxt;
  logic           rv_r, rv_nxt;

  // Case/space machine.
  logic [1:0] pend_r, pend_nxt;
  logic [1:0] act_r, act_nxt;
  logic       sp_r, sp_nxt;
  logic       esc_r, esc_nxt;

  // One emitted byte is held back until it is known whether it is the last.
  logic [BW-1:0] hold_b_r, hold_b_nxt;
  logic          hold_v_r, hold_v_nxt;

  dscsd_pkg::out_t out_r, out_nxt;
  logic            out_v_r, out_v_nxt;

  // Memory ports.
  logic           sym_ok;
  logic           pos_ok;
  logic [WIW-1:0] word_idx;
  logic [ABW-1:0] wr_addr;
  logic [ABW-1:0] rd_addr;
  logic [BW-1:0]  byte_rd;
  logic [LW-1:0]  len_rd;
  logic [LW-1:0]  len_wr;

  // Machine step on the byte read.
  logic          emit;
  logic [BW-1:0] ob;

  assign sym_ok   = (17'(in_data.symbol) < 17'(NUM_WORDS));
  assign pos_ok   = (7'(in_data.position) < 7'(WORD_SLOTS));
  assign word_idx = in_data.symbol[WIW-1:0];
  assign wr_addr  = ABW'(word_idx) * ABW'(WORD_SLOTS) + ABW'(in_data.position);
  assign rd_addr  = base_r + ABW'(idx_r);
  assign len_wr   = LW'(in_data.position) + LW'(1);

  dscsd_ram #(
    .WIDTH (BW),
    .DEPTH (BYTE_DEPTH)
  ) u_byte_ram (
    .clk   (clk),
    .we    (cmd.load && sym_ok && pos_ok),
    .waddr (wr_addr),
    .wdata (in_data.load_byte),
    .raddr (rd_addr),
    .rdata (byte_rd)
  );

  dscsd_ram #(
    .WIDTH (LW),
    .DEPTH (NUM_WORDS)
  ) u_len_ram (
    .clk   (clk),
    .we    (cmd.load && sym_ok && pos_ok && in_data.load_last),
    .waddr (word_idx),
    .wdata (len_wr),
    .raddr (word_idx),
    .rdata (len_rd)
  );

  assign sts.bad  = !sym_ok || (in_data.symbol >= {2'b00, word_count_r});
  assign sts.more = (idx_r < len_r);
  assign sts.rv   = rv_r;

  always_comb begin
    emit     = 1'b0;
    ob       = byte_rd;
    pend_nxt = pend_r;
    act_nxt  = act_r;
    sp_nxt   = sp_r;
    esc_nxt  = esc_r;
    if (esc_r) begin
      esc_nxt = 1'b0;
      emit    = 1'b1;
    end else if ((byte_rd == dscsd_pkg::CTL_CAPS_ALL) ||
                 (byte_rd == dscsd_pkg::CTL_CAPS_FIRST)) begin
      pend_nxt = byte_rd[1:0];
    end else if (byte_rd == dscsd_pkg::CTL_NOSPACE) begin
      sp_nxt = 1'b0;
    end else if (byte_rd == dscsd_pkg::CTL_LITERAL) begin
      esc_nxt = 1'b1;
    end else if (byte_rd == dscsd_pkg::CH_SPACE) begin
      act_nxt  = pend_r;
      pend_nxt = 2'd0;
      sp_nxt   = 1'b1;
      emit     = sp_r;
    end else begin
      if ((act_r == dscsd_pkg::CTL_CAPS_ALL[1:0]) ||
          (act_r == dscsd_pkg::CTL_CAPS_FIRST[1:0])) begin
        if ((byte_rd >= dscsd_pkg::CH_LOWER_A) && (byte_rd <= dscsd_pkg::CH_LOWER_Z)) begin
          ob = byte_rd - dscsd_pkg::CH_LOWER_A + dscsd_pkg::CH_UPPER_A;
        end
        if (act_r == dscsd_pkg::CTL_CAPS_FIRST[1:0]) begin
          act_nxt = 2'd0;
        end
      end
      sp_nxt = 1'b1;
      emit   = 1'b1;
    end
    // The machine only moves on a byte that was actually read.
    if (!rv_r) begin
      emit     = 1'b0;
      pend_nxt = pend_r;
      act_nxt  = act_r;
      sp_nxt   = sp_r;
      esc_nxt  = esc_r;
    end
    if (cmd.restart) begin
      pend_nxt = 2'd0;
      act_nxt  = 2'd0;
      sp_nxt   = 1'b1;
      esc_nxt  = 1'b0;
    end
  end

  always_comb begin
    base_nxt   = base_r;
    len_nxt    = len_r;
    idx_nxt    = idx_r;
    rv_nxt     = 1'b0;
    hold_b_nxt = hold_b_r;
    hold_v_nxt = hold_v_r;
    out_nxt    = out_r;
    out_v_nxt  = 1'b0;

    if (cmd.dec) begin
      base_nxt = ABW'(word_idx) * ABW'(WORD_SLOTS);
    end
    if (cmd.len_latch) begin
      idx_nxt = '0;
      if ({1'b0, len_rd} > 7'(WORD_SLOTS)) begin
        len_nxt = LW'(WORD_SLOTS);
      end else begin
        len_nxt = len_rd;
      end
    end
    if (cmd.issue) begin
      idx_nxt = idx_r + LW'(1);
      rv_nxt  = 1'b1;
    end
    if (cmd.bad) begin
      out_v_nxt = 1'b1;
      out_nxt   = '{out_byte: '0, byte_valid: 1'b0, bad_symbol: 1'b1, last: 1'b1};
    end
    if (emit) begin
      if (hold_v_r) begin
        out_v_nxt = 1'b1;
        out_nxt   = '{out_byte: hold_b_r, byte_valid: 1'b1, bad_symbol: 1'b0, last: 1'b0};
      end
      hold_b_nxt = ob;
      hold_v_nxt = 1'b1;
    end
    if (cmd.finish) begin
      out_v_nxt = 1'b1;
      if (hold_v_r) begin
        out_nxt = '{out_byte: hold_b_r, byte_valid: 1'b1, bad_symbol: 1'b0, last: 1'b1};
      end else begin
        out_nxt = '{out_byte: '0, byte_valid: 1'b0, bad_symbol: 1'b0, last: 1'b1};
      end
      hold_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_count_r <= '0;
      pend_r       <= 2'd0;
      act_r        <= 2'd0;
      sp_r         <= 1'b1;
      esc_r        <= 1'b0;
      rv_r         <= 1'b0;
      hold_v_r     <= 1'b0;
      out_v_r      <= 1'b0;
      len_r        <= '0;
      idx_r        <= '0;
    end else begin
      if (cfg_we) begin
        word_count_r <= cfg_wdata;
      end
      pend_r   <= pend_nxt;
      act_r    <= act_nxt;
      sp_r     <= sp_nxt;
      esc_r    <= esc_nxt;
      rv_r     <= rv_nxt;
      hold_v_r <= hold_v_nxt;
      out_v_r  <= out_v_nxt;
      len_r    <= len_nxt;
      idx_r    <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    base_r   <= base_nxt;
    hold_b_r <= hold_b_nxt;
    out_r    <= out_nxt;
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  a_bad_is_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_r.bad_symbol |-> out_r.last && !out_r.byte_valid)
    else $error("invalid-symbol result is not a lone final result");

  a_empty_is_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !out_r.byte_valid |-> out_r.last && (out_r.out_byte == '0))
    else $error("empty result is not final or carries a byte");

  a_nonlast_keeps_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !out_r.last |-> hold_v_r)
    else $error("non-final byte sent without a byte held behind it");

  a_finish_drains: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> !rv_r && !(idx_r < len_r))
    else $error("decode finished with word bytes outstanding");
`endif

endmodule

/* design/dictionary_symbol_case_space_decoder_core.sv */
// Dictionary symbol decoder with case/space restoration.
// Input: an item is taken at a rising edge where start is high and busy is low.
// Function 0 stores one dictionary byte (and the word length on the final byte),
// function 2 restarts the case/space state; both give no result.
// Function 1 decodes a symbol. An invalid symbol (not below word_count or the
// dictionary size) gives one bad_symbol beat on the next cycle and leaves busy low.
// A valid symbol raises busy: the controller reads the word length, reads the
// stored bytes one per cycle, passes the last byte through the case/space machine
// and sends the final beat; busy stays high throughout, and the next item can be
// taken only once busy is low again.
// The single read port of the byte memory sets this pace.
// Results: each beat appears for exactly one cycle with out_valid high. One emitted
// byte is held back so the final beat can carry last; the final beat appears in the
// first cycle with busy low again. A word that emits nothing gives one empty last beat.
// The receiver cannot stall; it must take every beat as it appears.
// cfg_we writes word_count; the user must do so only while the block is idle, as the
// block does not enforce it. Reset clears word_count to zero and the case/space state.
// The dictionary memories are not cleared; a word must be loaded before it is decoded.
module dictionary_symbol_case_space_decoder_core #(
  parameter int NUM_WORDS  = dscsd_pkg::NUM_WORDS_DEF,
  parameter int WORD_SLOTS = dscsd_pkg::WORD_SLOTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // Command channel.
  input  logic                          start,
  output logic                          busy,
  input  dscsd_pkg::in_t                in_data,
  // Result channel.
  output logic                          out_valid,
  output dscsd_pkg::out_t               out_data,
  // Configuration port.
  input  logic                          cfg_we,
  input  logic [dscsd_pkg::COUNT_W-1:0] cfg_wdata
);

  dscsd_pkg::dp_cmd_t cmd;
  dscsd_pkg::dp_sts_t sts;

  // The controller sequences each command; the datapath holds the memories,
  // the case/space machine and the output register.
  dscsd_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .func  (in_data.func),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  dscsd_dp #(
    .NUM_WORDS  (NUM_WORDS),
    .WORD_SLOTS (WORD_SLOTS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
